@@ src/integer_calculator_alu_core_defines.svh @@
// Assertion macros used by the port-level checker
`ifndef INTEGER_CALCULATOR_ALU_CORE_DEFINES_SVH
`define INTEGER_CALCULATOR_ALU_CORE_DEFINES_SVH

// Check an implication on every rising clock edge outside reset
`define ICA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that an implication's consequent holds in the cycle after its antecedent
`define ICA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/ica_pkg.sv @@
// ----------------------------------------------------------------------------
// ica_pkg
// Operation codes, widths and controller/datapath command types.
// ----------------------------------------------------------------------------
package ica_pkg;

    localparam int RES_W = 48;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_POW  = 3'd4,
        OP_FACT = 3'd5,
        OP_PERM = 3'd6,
        OP_COMB = 3'd7
    } t_op;

    // datapath micro-commands
    typedef enum logic [3:0] {
        CMD_NONE     = 4'd0,
        CMD_LOAD     = 4'd1,  // capture operands
        CMD_SIMPLE   = 4'd2,  // add/sub/mul into result
        CMD_POW_INIT = 4'd3,
        CMD_POW_STEP = 4'd4,
        CMD_FACT_INIT= 4'd5,  // arg select in fsel
        CMD_FACT_STEP= 4'd6,
        CMD_DIV_INIT = 4'd7,  // dsel selects operands
        CMD_DIV_STEP = 4'd8,
        CMD_DIV_DONE = 4'd9
    } t_cmd;

    // factorial argument / destination
    typedef enum logic [1:0] {
        FS_A  = 2'd0,  // n! -> fa
        FS_AB = 2'd1,  // (n-r)! -> fb
        FS_B  = 2'd2   // r! -> fc
    } t_fsel;

    // divide setup
    typedef enum logic [1:0] {
        DS_FIX  = 2'd0,  // a*2^F / b
        DS_PERM = 2'd1,  // fa / fb
        DS_COMB = 2'd2   // q / fc
    } t_dsel;

    typedef struct packed {
        t_cmd  cmd;
        t_fsel fsel;
        t_dsel dsel;
    } t_ctl;

    typedef struct packed {
        logic op_done;   // pow or fact iteration finished
        logic div_done;  // divider finished its bits
        logic div_zero;  // divisor of current division is zero
    } t_sts;

endpackage

@@ src/integer_calculator_alu_core.sv @@
// Integer calculator ALU core.
// Input stream: s_axis_tdata carries operand_a and operand_b, s_axis_tuser the
// operation code. Output stream: m_axis_tdata carries the 48-bit result,
// m_axis_tuser the status bit (1 = zero divisor inside permutation/combination).
// One item is in flight at a time; s_axis_tready is high only when idle.
// Per operation: add/sub/mul write the result directly; divide: one serial
//   divide; power: square-and-multiply, one multiply per cycle; factorial:
//   repeated multiply; permutation: two factorials plus one serial divide;
//   combination: three factorials plus two serial divides. The shared
//   multiplier and the one-bit-per-cycle divider perform these steps.
// The result is held on m_axis_tdata while m_axis_tready is low; a new item
// is taken the cycle after the result transaction.
// Synchronous active-low reset returns the sequencer to idle; no state is kept
// between items.
// ----------------------------------------------------------------------------
// integer_calculator_alu_core
// Top level: stream ports, controller and datapath.
// ----------------------------------------------------------------------------
module integer_calculator_alu_core import ica_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] operand_a, [63:32] operand_b
    input  logic [2:0]  s_axis_tuser,   // [2:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [47:0] result
    output logic        m_axis_tuser    // [0] status
);

    t_ctl w_ctl;
    t_sts w_sts;
    logic signed [RES_W-1:0] w_result;

    ica_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_op        (t_op'(s_axis_tuser)),
        .i_sts       (w_sts),
        .o_ctl       (w_ctl),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_status    (m_axis_tuser)
    );

    ica_datapath #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_a      (s_axis_tdata[DATA_WIDTH-1:0]),
        .i_b      (s_axis_tdata[32 +: DATA_WIDTH]),
        .i_op     (t_op'(s_axis_tuser)),
        .o_sts    (w_sts),
        .o_result (w_result)
    );

    assign m_axis_tdata = w_result;

endmodule

@@ src/ica_datapath.sv @@
// ----------------------------------------------------------------------------
// ica_datapath
// Operand registers, shared multiplier, bit-serial restoring divider.
// ----------------------------------------------------------------------------
module ica_datapath import ica_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ctl                    i_ctl,
    input  logic [DATA_WIDTH-1:0]   i_a,
    input  logic [DATA_WIDTH-1:0]   i_b,
    input  t_op                     i_op,
    output t_sts                    o_sts,
    output logic signed [RES_W-1:0] o_result
);

    localparam int DW = DATA_WIDTH;
    localparam int NW = DW + FRAC_BITS + 1;  // divider magnitude width
    localparam int CW = $clog2(NW + 1);
    localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};

    logic [DW-1:0] r_a, r_b, r_fa, r_fb, r_fc, r_acc, r_sq, r_cnt;
    logic [DW-1:0] r_exp;
    t_op           r_op;
    logic          r_fact_zero;
    logic [1:0]    r_fdst;
    logic [NW-1:0] r_quo, r_den;
    logic [NW:0]   r_rem;
    logic [CW-1:0] r_bits;
    logic          r_neg, r_dfix;
    logic signed [RES_W-1:0] r_res;

    logic [DW-1:0] w_diff, w_fact_arg, w_mul_x, w_mul_y, w_prod;
    logic [NW-1:0] w_num_mag, w_den_mag;
    logic signed [NW:0] w_num_s, w_den_s;
    logic [NW:0]   w_trial;
    logic signed [NW:0] w_q_s;
    logic signed [63:0] w_q_ext;

    assign w_diff = r_a - r_b;

    always_comb begin
        case (i_ctl.fsel)
            FS_A:    w_fact_arg = r_a;
            FS_AB:   w_fact_arg = w_diff;
            default: w_fact_arg = r_b;
        endcase
    end

    // one shared DW x DW multiplier, low half only
    always_comb begin
        w_mul_x = r_acc;
        w_mul_y = r_cnt;
        case (i_ctl.cmd)
            CMD_SIMPLE:   begin w_mul_x = r_a;   w_mul_y = r_b;   end
            CMD_POW_STEP: begin
                w_mul_x = r_exp[0] ? r_acc : r_sq;
                w_mul_y = r_sq;
            end
            default:      begin w_mul_x = r_acc; w_mul_y = r_cnt; end
        endcase
    end
    assign w_prod = w_mul_x * w_mul_y;

    // divider operand selection, sign-extended
    always_comb begin
        case (i_ctl.dsel)
            DS_FIX: begin
                w_num_s = (NW+1)'($signed(r_a)) <<< FRAC_BITS;
                w_den_s = (NW+1)'($signed(r_b));
            end
            DS_PERM: begin
                w_num_s = (NW+1)'($signed(r_fa));
                w_den_s = (NW+1)'($signed(r_fb));
            end
            default: begin
                w_num_s = (NW+1)'($signed(r_quo[DW-1:0]));
                w_den_s = (NW+1)'($signed(r_fc));
            end
        endcase
        w_num_mag = w_num_s[NW] ? NW'(-w_num_s) : w_num_s[NW-1:0];
        w_den_mag = w_den_s[NW] ? NW'(-w_den_s) : w_den_s[NW-1:0];
    end

    assign w_trial = {r_rem[NW-1:0], r_quo[NW-1]} - {1'b0, r_den};
    assign w_q_s   = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign w_q_ext = 64'(w_q_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= '0;
        end else begin
            case (i_ctl.cmd)
                CMD_LOAD: begin
                    r_a <= i_a;
                    r_b <= i_b;
                    r_op <= i_op;
                    r_res <= '0;
                end
                CMD_SIMPLE: begin
                    case (r_op)
                        OP_ADD:  r_res <= RES_W'($signed(r_a + r_b));
                        OP_SUB:  r_res <= RES_W'($signed(w_diff));
                        default: r_res <= RES_W'($signed(w_prod));
                    endcase
                end
                CMD_POW_INIT: begin
                    // negative exponent: result is the base itself
                    r_acc <= r_b[DW-1] ? r_a : DW'(1);
                    r_sq  <= r_a;
                    r_exp <= r_b[DW-1] ? '0 : r_b;
                end
                CMD_POW_STEP: begin
                    // alternate: bit set -> multiply acc first, then square
                    if (r_exp[0]) begin
                        r_acc <= w_prod;
                        r_exp <= r_exp & ~DW'(1);
                    end else begin
                        r_sq  <= w_prod;
                        r_exp <= r_exp >> 1;
                    end
                    if (r_exp == '0)
                        r_res <= RES_W'($signed(r_acc));
                end
                CMD_FACT_INIT: begin
                    r_acc <= DW'(1);
                    r_cnt <= DW'(2);
                    r_exp <= w_fact_arg;
                    r_fdst <= i_ctl.fsel;
                    r_fact_zero <= ~w_fact_arg[DW-1] && (w_fact_arg >= DW'(34));
                end
                CMD_FACT_STEP: begin
                    if ($signed(r_cnt) <= $signed(r_exp) && !r_fact_zero) begin
                        r_acc <= w_prod;
                        r_cnt <= r_cnt + DW'(1);
                    end else begin
                        case (r_fdst)
                            FS_A:    r_fa <= r_fact_zero ? '0 : r_acc;
                            FS_AB:   r_fb <= r_fact_zero ? '0 : r_acc;
                            default: r_fc <= r_fact_zero ? '0 : r_acc;
                        endcase
                        r_res <= RES_W'($signed(r_fact_zero ? '0 : r_acc));
                    end
                end
                CMD_DIV_INIT: begin
                    r_quo  <= w_num_mag;
                    r_den  <= w_den_mag;
                    r_rem  <= '0;
                    r_neg  <= w_num_s[NW] ^ w_den_s[NW];
                    r_bits <= CW'(NW);
                    r_dfix <= (i_ctl.dsel == DS_FIX);
                    // zero divisor: result is 0
                    if (w_den_mag == '0)
                        r_res <= '0;
                end
                CMD_DIV_STEP: begin
                    if (!w_trial[NW]) begin
                        r_rem <= w_trial;
                        r_quo <= {r_quo[NW-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[NW-1:0], r_quo[NW-1]};
                        r_quo <= {r_quo[NW-2:0], 1'b0};
                    end
                    r_bits <= r_bits - CW'(1);
                end
                CMD_DIV_DONE: begin
                    r_quo <= NW'(w_q_s);
                    if (r_dfix) begin
                        // only min / -1 overflows the result range
                        if (w_q_ext > 64'(RES_MAX))
                            r_res <= RES_MAX;
                        else
                            r_res <= RES_W'(w_q_s);
                    end else begin
                        r_res <= RES_W'($signed(w_q_s[DW-1:0]));
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_sts.op_done  = (i_ctl.cmd == CMD_POW_STEP) ? (r_exp == '0)
                          : !($signed(r_cnt) <= $signed(r_exp) && !r_fact_zero);
    assign o_sts.div_done = (r_bits == '0);
    assign o_sts.div_zero = (w_den_mag == '0);
    assign o_result       = r_res;

endmodule

@@ src/ica_ctrl.sv @@
// ----------------------------------------------------------------------------
// ica_ctrl
// Sequencer: issues datapath commands per operation and runs the handshake.
// ----------------------------------------------------------------------------
module ica_ctrl import ica_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_op  i_op,
    input  t_sts i_sts,
    output t_ctl o_ctl,
    output logic o_out_valid,
    input  logic i_out_ready,
    output logic o_status
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DISP  = 9'b000000010,
        S_POW   = 9'b000000100,
        S_FINIT = 9'b000001000,
        S_FACT  = 9'b000010000,
        S_DINIT = 9'b000100000,
        S_DIV   = 9'b001000000,
        S_DDONE = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    t_fsel  r_fsel, n_fsel;
    t_dsel  r_dsel, n_dsel;
    logic   r_status, n_status;

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_fsel   = r_fsel;
        n_dsel   = r_dsel;
        n_status = r_status;
        o_ctl    = '{cmd: CMD_NONE, fsel: r_fsel, dsel: r_dsel};
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.cmd = CMD_LOAD;
                    n_op      = i_op;
                    n_status  = 1'b0;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                case (r_op)
                    OP_ADD, OP_SUB, OP_MUL: begin
                        o_ctl.cmd = CMD_SIMPLE;
                        n_state   = S_OUT;
                    end
                    OP_DIV: begin
                        n_dsel  = DS_FIX;
                        n_state = S_DINIT;
                    end
                    OP_POW: begin
                        o_ctl.cmd = CMD_POW_INIT;
                        n_state   = S_POW;
                    end
                    default: begin
                        n_fsel  = FS_A;
                        n_state = S_FINIT;
                    end
                endcase
            end
            S_POW: begin
                o_ctl.cmd = CMD_POW_STEP;
                if (i_sts.op_done)
                    n_state = S_OUT;
            end
            S_FINIT: begin
                o_ctl.cmd = CMD_FACT_INIT;
                n_state   = S_FACT;
            end
            S_FACT: begin
                o_ctl.cmd = CMD_FACT_STEP;
                if (i_sts.op_done) begin
                    if (r_op == OP_FACT || r_fsel == FS_B) begin
                        n_state = (r_op == OP_FACT) ? S_OUT : S_DINIT;
                        n_dsel  = DS_PERM;
                    end else if (r_fsel == FS_A) begin
                        n_fsel  = FS_AB;
                        n_state = S_FINIT;
                    end else if (r_op == OP_COMB) begin
                        n_fsel  = FS_B;
                        n_state = S_FINIT;
                    end else begin
                        n_dsel  = DS_PERM;
                        n_state = S_DINIT;
                    end
                end
            end
            S_DINIT: begin
                o_ctl.cmd = CMD_DIV_INIT;
                n_state   = S_DIV;
                if (i_sts.div_zero) begin
                    n_status  = (r_op != OP_DIV);
                    n_state   = S_OUT;  // datapath clears the result
                end
            end
            S_DIV: begin
                o_ctl.cmd = CMD_DIV_STEP;
                if (i_sts.div_done) begin
                    o_ctl.cmd = CMD_DIV_DONE;
                    n_state   = S_DDONE;
                end
            end
            S_DDONE: begin
                if (r_op == OP_COMB && r_dsel == DS_PERM) begin
                    n_dsel  = DS_COMB;
                    n_state = S_DINIT;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_ready)
                    n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= OP_ADD;
            r_fsel   <= FS_A;
            r_dsel   <= DS_FIX;
            r_status <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_fsel   <= n_fsel;
            r_dsel   <= n_dsel;
            r_status <= n_status;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_status    = r_status;

endmodule

@@ src/ica_checker.sv @@
// ----------------------------------------------------------------------------
// ica_checker
// Port-level checks on the calculator core, bound to the top level.
// ----------------------------------------------------------------------------
`include "integer_calculator_alu_core_defines.svh"

module ica_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    `ICA_ASSERT_IMPL(a_one_in_flight, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready, "input open while result pending")
    `ICA_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready && !m_axis_tvalid, "not busy after input transaction")
    `ICA_ASSERT_NEXT(a_hold_result, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
    `ICA_ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 48'd0, "error status with nonzero result")

endmodule

bind integer_calculator_alu_core ica_checker u_ica_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ bench/integer_calculator_alu_core_checker.sv @@
// ----------------------------------------------------------------------------
// integer_calculator_alu_core_checker
// Watches both streams, predicts each result and compares it in order.
// ----------------------------------------------------------------------------
module integer_calculator_alu_core_checker import ica_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic [2:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [47:0] value;
        logic        zero_div;
    } t_calc;

    t_calc calc_q[$];

    function automatic logic signed [63:0] factorial32(logic signed [63:0] n);
        logic [31:0] acc;
        acc = 32'd1;
        if (n < 0) return 64'sd1;
        if (n >= 34) return 64'sd0;
        for (int i = 2; i <= n; i++) acc = acc * i[31:0];
        return 64'(signed'(acc));
    endfunction

    function automatic logic signed [63:0] power32(logic signed [31:0] base,
                                                   logic signed [31:0] ex);
        logic [31:0] acc, sq, k;
        if (ex == 0) return 64'sd1;
        if (ex < 0) return 64'(base);
        acc = 32'd1;
        sq  = base;
        k   = ex;
        while (k != 0) begin
            if (k[0]) acc = acc * sq;
            sq = sq * sq;
            k  = k >> 1;
        end
        return 64'(signed'(acc));
    endfunction

    function automatic t_calc calc_result(t_op op, logic signed [31:0] a,
                                          logic signed [31:0] b);
        t_calc r;
        logic signed [63:0] num, den, q;
        logic signed [31:0] diff;
        r = '0;
        diff = a - b;
        case (op)
            OP_ADD: r.value = 48'(signed'(32'(a + b)));
            OP_SUB: r.value = 48'(signed'(diff));
            OP_MUL: r.value = 48'(signed'(32'(a * b)));
            OP_DIV: begin
                // 48-bit range covers every quotient but a = min, b = -1
                if (b != 0) begin
                    q = (64'(a) <<< 16) / 64'(b);
                    if (q > 64'sh7FFF_FFFF_FFFF) q = 64'sh7FFF_FFFF_FFFF;
                    r.value = q[47:0];
                end
            end
            OP_POW: begin
                q = power32(a, b);
                r.value = q[47:0];
            end
            OP_FACT: begin
                q = factorial32(64'(a));
                r.value = q[47:0];
            end
            default: begin
                num = factorial32(64'(a));
                den = factorial32(64'(diff));
                if (den == 0) r.zero_div = 1'b1;
                else begin
                    q = 64'(signed'(32'(num / den)));
                    if (op == OP_COMB) begin
                        den = factorial32(64'(b));
                        if (den == 0) r.zero_div = 1'b1;
                        else q = 64'(signed'(32'(q / den)));
                    end
                    if (!r.zero_div) r.value = q[47:0];
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_calc want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_pending <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                calc_q.push_back(calc_result(t_op'(s_axis_tuser), s_axis_tdata[31:0],
                                             s_axis_tdata[63:32]));
            if (m_axis_tvalid && m_axis_tready) begin
                if (calc_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result %h/%b", m_axis_tdata, m_axis_tuser);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = calc_q.pop_front();
                    if (want.value !== m_axis_tdata || want.zero_div !== m_axis_tuser) begin
                        if (o_fail_count < 10)
                            $display("mismatch: exp %h/%b got %h/%b", want.value,
                                     want.zero_div, m_axis_tdata, m_axis_tuser);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= calc_q.size();
        end
    end
endmodule

@@ bench/tb_integer_calculator_alu_core.sv @@
// ----------------------------------------------------------------------------
// tb_integer_calculator_alu_core
// Directed corner operations, then random operations with random gaps and
// output stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_integer_calculator_alu_core import ica_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;
    int          fail_count, pending;
    bit          stim_done = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    integer_calculator_alu_core DUT (.*);
    integer_calculator_alu_core_checker u_checker (.*, .o_fail_count(fail_count),
                                                   .o_pending(pending));

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
        return $urandom_range(3, 40);
    endfunction

    // output stall pattern; some stretches with ready held high
    always @(posedge i_clk) begin
        if (!i_rst_n || stim_done) m_axis_tready <= 1'b1;
        else if ($urandom_range(0, 199) < 3) m_axis_tready <= 1'b1;
        else if (m_axis_tready) m_axis_tready <= ($urandom_range(0, 9) < 7);
        else m_axis_tready <= ($urandom_range(0, 9) < 3);
    end

    function automatic logic [31:0] rand_operand(t_op op);
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'd0;
            4, 5, 6: return (op >= OP_POW) ? $urandom_range(0, 40) - 3 : $urandom_range(0, 20);
            default: return $urandom;
        endcase
    endfunction

    task automatic send(t_op op, logic [31:0] a, logic [31:0] b);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {b, a};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        s_axis_tvalid <= 1'b0;
        repeat (gap_len()) @(posedge i_clk);
    endtask

    initial begin
        t_op op;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send(OP_ADD, 32'h7FFF_FFFF, 32'd1);
        send(OP_SUB, 32'h8000_0000, 32'd1);
        send(OP_MUL, 32'hFFFF_FFFF, 32'h8000_0000);
        send(OP_DIV, 32'd7, 32'd0);
        send(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        send(OP_DIV, 32'hFFFF_FFF9, 32'd2);
        send(OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000);
        send(OP_POW, 32'd3, 32'd0);
        send(OP_POW, 32'd5, 32'hFFFF_FFFF);
        send(OP_POW, 32'd3, 32'h7FFF_FFFF);
        send(OP_FACT, 32'hFFFF_FFFB, 32'd0);
        send(OP_FACT, 32'd33, 32'd0);
        send(OP_FACT, 32'd34, 32'd0);
        send(OP_FACT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send(OP_PERM, 32'd10, 32'd3);
        send(OP_PERM, 32'd40, 32'd2);
        send(OP_PERM, 32'd5, 32'd9);
        send(OP_COMB, 32'd10, 32'd3);
        send(OP_COMB, 32'd12, 32'd40);
        send(OP_COMB, 32'd34, 32'd34);
        send(OP_COMB, 32'h8000_0000, 32'h7FFF_FFFF);
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        for (int n = 0; n < 1100; n++) begin
            op = t_op'($urandom_range(0, 7));
            send(op, rand_operand(op), rand_operand(op));
            if (n == 500) begin
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
        end
        stim_done = 1'b1;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule

@@ integer_calculator_alu_core.f @@
+incdir+src
src/ica_pkg.sv
src/ica_datapath.sv
src/ica_ctrl.sv
src/integer_calculator_alu_core.sv
src/ica_checker.sv
bench/integer_calculator_alu_core_checker.sv
bench/tb_integer_calculator_alu_core.sv
